[hdl/lcfc_pkg.sv]
// ----------------------------------------------------------------------------
// lcfc_pkg
// Shared types and constants for the light channel fade controller.
// ----------------------------------------------------------------------------
package lcfc_pkg;

	localparam int DUTY_W   = 8;
	localparam int COUNT_W  = 16;
	localparam int EVENT_W  = 3;
	localparam int MODE_W   = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [DUTY_W-1:0]  DUTY_FULL = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [COUNT_W-1:0] CUTOFF_RESET     = 16'd600;
	localparam logic [COUNT_W-1:0] EXIT_DELAY_RESET = 16'd30;

	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_DELAY = 1'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT       = 3'd0,
		MODE_OFF        = 3'd1,
		MODE_FADE_IN    = 3'd2,
		MODE_ON         = 3'd3,
		MODE_EXIT_DELAY = 3'd4,
		MODE_FADE_OUT   = 3'd5
	} mode_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_OPEN      = 3'd0,
		EV_CLOSE     = 3'd1,
		EV_CLOSE_AMB = 3'd2,
		EV_AMB_ON    = 3'd3,
		EV_NOOP      = 3'd4,
		EV_COMPLETE  = 3'd5,
		EV_CUTOFF    = 3'd6,
		EV_TICK      = 3'd7
	} event_t;

	typedef struct packed {
		mode_t              mode;
		logic [DUTY_W-1:0]  duty;
		logic [COUNT_W-1:0] on_seconds;
		logic [COUNT_W-1:0] delay_seconds;
		logic               settled_off;
	} lcfc_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] cutoff_seconds;
		logic [COUNT_W-1:0] exit_delay_seconds;
	} lcfc_cfg_t;

endpackage

[hdl/lcfc_cfg.sv]
// ----------------------------------------------------------------------------
// lcfc_cfg
// Configuration registers: cutoff time and exit delay, in seconds.
// ----------------------------------------------------------------------------
module lcfc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcfc_pkg::COUNT_W-1:0]      cfg_data,
	output lcfc_pkg::lcfc_cfg_t               cfg
);
	import lcfc_pkg::*;

	lcfc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff_seconds     <= CUTOFF_RESET;
			cfg_q.exit_delay_seconds <= EXIT_DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CUTOFF:     cfg_q.cutoff_seconds     <= cfg_data;
				REG_EXIT_DELAY: cfg_q.exit_delay_seconds <= cfg_data;
				default:        cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/lcfc_next.sv]
// ----------------------------------------------------------------------------
// lcfc_next
// Next-state logic: mode transitions and duty / counter updates per event.
// ----------------------------------------------------------------------------
module lcfc_next (
	input  lcfc_pkg::lcfc_state_t          cur,
	input  logic [lcfc_pkg::EVENT_W-1:0]   event_code,
	input  lcfc_pkg::lcfc_cfg_t            cfg,
	output lcfc_pkg::lcfc_state_t          nxt
);
	import lcfc_pkg::*;

	event_t             ev;
	logic [COUNT_W-1:0] on_inc;
	logic [COUNT_W-1:0] delay_inc;
	mode_t              mode_nxt;

	assign ev        = event_t'(event_code);
	assign on_inc    = (cur.on_seconds == COUNT_MAX) ? COUNT_MAX : cur.on_seconds + 1'b1;
	assign delay_inc = (cur.delay_seconds == COUNT_MAX) ? COUNT_MAX
		: cur.delay_seconds + 1'b1;

	// next mode
	always_comb begin
		mode_nxt = cur.mode;
		case (cur.mode)
			MODE_OFF: begin
				if (ev == EV_OPEN) mode_nxt = MODE_FADE_IN;
			end
			MODE_FADE_IN: begin
				if (ev == EV_COMPLETE) mode_nxt = MODE_ON;
				else if (ev == EV_CLOSE || ev == EV_CLOSE_AMB) mode_nxt = MODE_FADE_OUT;
				else if (ev == EV_NOOP && cur.duty == DUTY_FULL) mode_nxt = MODE_ON;
			end
			MODE_ON: begin
				if (ev == EV_CLOSE) mode_nxt = MODE_EXIT_DELAY;
				else if (ev == EV_CUTOFF || ev == EV_CLOSE_AMB) mode_nxt = MODE_FADE_OUT;
				else if (ev == EV_TICK && on_inc >= cfg.cutoff_seconds)
					mode_nxt = MODE_FADE_OUT;
			end
			MODE_EXIT_DELAY: begin
				if (ev == EV_OPEN) mode_nxt = MODE_ON;
				else if (ev == EV_COMPLETE || ev == EV_AMB_ON) mode_nxt = MODE_FADE_OUT;
				else if (ev == EV_TICK && delay_inc >= cfg.exit_delay_seconds)
					mode_nxt = MODE_FADE_OUT;
			end
			MODE_FADE_OUT: begin
				if (ev == EV_COMPLETE) mode_nxt = MODE_OFF;
				else if (ev == EV_OPEN) mode_nxt = MODE_FADE_IN;
				else if (ev == EV_NOOP && cur.duty == '0) mode_nxt = MODE_OFF;
			end
			default: begin
				if (ev == EV_OPEN) mode_nxt = MODE_FADE_IN;
				else if (ev == EV_CLOSE || ev == EV_CLOSE_AMB || ev == EV_NOOP)
					mode_nxt = MODE_OFF;
			end
		endcase
	end

	// duty, counters, settle flag
	always_comb begin
		nxt      = cur;
		nxt.mode = mode_nxt;
		case (cur.mode)
			MODE_OFF: begin
				if (ev == EV_OPEN) nxt.settled_off = 1'b0;
				else if (ev == EV_NOOP) begin
					nxt.settled_off = 1'b1;
					nxt.duty        = '0;
				end
			end
			MODE_FADE_IN: begin
				if (ev == EV_COMPLETE) nxt.on_seconds = '0;
				else if (ev == EV_NOOP) begin
					if (cur.duty == DUTY_FULL) nxt.on_seconds = '0;
					else nxt.duty = cur.duty + 1'b1;
				end
			end
			MODE_ON: begin
				if (ev == EV_CLOSE) nxt.delay_seconds = '0;
				else if (ev == EV_TICK) nxt.on_seconds = on_inc;
				else if (ev == EV_NOOP) nxt.duty = DUTY_FULL;
			end
			MODE_EXIT_DELAY: begin
				if (ev == EV_OPEN) nxt.on_seconds = '0;
				else if (ev == EV_TICK) nxt.delay_seconds = delay_inc;
			end
			MODE_FADE_OUT: begin
				if (ev == EV_NOOP && cur.duty != '0) nxt.duty = cur.duty - 1'b1;
			end
			default: begin
				nxt.duty = cur.duty;
			end
		endcase
	end

endmodule

[hdl/light_channel_fade_controller.sv]
// ----------------------------------------------------------------------------
// light_channel_fade_controller
// Event-driven fade controller for one dimmable light channel.
// ----------------------------------------------------------------------------
// Result: an accepted event updates the state register; its result is valid in the cycle after its transaction.
// Throughput: one event per cycle; the state register doubles as the result
// register, so input stalls only while a result is held by output stall.
// Reset: asynchronous, active low; mode init, duty and counters zero,
// cutoff 600 s and exit delay 30 s.
module light_channel_fade_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lcfc_pkg::EVENT_W-1:0]      event_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lcfc_pkg::DUTY_W-1:0]       duty_level,
	output logic                              off_flag,
	output logic [lcfc_pkg::MODE_W-1:0]       state_code,
	input  logic                              cfg_we,
	input  logic [lcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcfc_pkg::COUNT_W-1:0]      cfg_data
);
	import lcfc_pkg::*;

	lcfc_cfg_t   cfg;
	lcfc_state_t state_q;
	lcfc_state_t state_nxt;
	logic        out_valid_q;
	logic        in_accept;

	lcfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcfc_next u_next (
		.cur        (state_q),
		.event_code (event_code),
		.cfg        (cfg),
		.nxt        (state_nxt)
	);

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_INIT;
			state_q.duty          <= '0;
			state_q.on_seconds    <= '0;
			state_q.delay_seconds <= '0;
			state_q.settled_off   <= 1'b0;
			out_valid_q           <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_nxt;
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign duty_level = state_q.duty;
	assign off_flag   = state_q.settled_off;
	assign state_code = state_q.mode;

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid)
		else $error("transaction accepted without a following result");

	a_settled_only_off: assert property (@(posedge clk) disable iff (!arst_n)
		off_flag |-> state_code == MODE_OFF)
		else $error("settled flag set outside off state");

	a_on_noop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && state_q.mode == MODE_ON && event_code == EV_NOOP)
		|=> duty_level == DUTY_FULL)
		else $error("noop in on state did not drive full duty");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> $stable(state_q))
		else $error("state changed without a transaction");
`endif

endmodule
